// ===== design/tsps_pkg.sv =====
`timescale 1ns / 1ps

package tsps_pkg;

  // Default geometry of the sync search
  localparam int PACKET_BYTES_DEFAULT    = 188;
  localparam int CONFIRM_PACKETS_DEFAULT = 4;

  // Sync byte value after reset
  localparam logic [7:0] SYNC_RESET = 8'h47;

  // Entries in the queue between classifier and lock tracker
  localparam int QUEUE_DEPTH = 4;

  // One classified byte, as handed from the front to the back
  typedef struct packed {
    logic [7:0] data;        // oldest byte of the delay line
    logic       head_match;  // that byte equals the sync value
    logic       all_match;   // it and every packet-spaced byte after it match
  } tsps_entry_t;

  // Lock tracker state
  typedef enum logic {
    TSPS_HUNT,
    TSPS_LOCK
  } tsps_state_t;

endpackage

// ===== design/tsps_front.sv =====
`timescale 1ns / 1ps

module tsps_front #(
  parameter int PACKET_BYTES    = tsps_pkg::PACKET_BYTES_DEFAULT,
  parameter int CONFIRM_PACKETS = tsps_pkg::CONFIRM_PACKETS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          sync_value,
  output logic                push,
  output tsps_pkg::tsps_entry_t entry
);

  localparam int Depth = PACKET_BYTES * CONFIRM_PACKETS;
  localparam int PtrW  = $clog2(PACKET_BYTES);
  localparam int FillW = $clog2(Depth);

  logic [PtrW-1:0]  ptr;
  logic [PtrW-1:0]  ptr_next;
  logic [PtrW-1:0]  rd_addr;
  logic [FillW-1:0] fill;
  logic [7:0]       tap [CONFIRM_PACKETS];
  logic [CONFIRM_PACKETS-1:0] tap_match;
  logic             full;

  // Advance the lane pointer once per item, wrapping at the packet length
  always_comb begin
    ptr_next = ptr;
    if (accept) begin
      ptr_next = (ptr == PtrW'(PACKET_BYTES - 1)) ? '0 : ptr + 1'b1;
    end
    rd_addr = (ptr_next == PtrW'(PACKET_BYTES - 1)) ? '0 : ptr_next + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else begin
      ptr <= ptr_next;
      if (accept && !full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  assign full = (fill == FillW'(Depth - 1));

  // One packet-long lane per confirm position; lane j taps the byte
  // (j+1)*PACKET_BYTES-1 items behind the newest one
  for (genvar j = 0; j < CONFIRM_PACKETS; j++) begin : g_lane
    logic [7:0] mem [PACKET_BYTES];
    logic [7:0] lane_in;
    logic [7:0] rd_data;

    if (j == 0) begin : g_head
      assign lane_in = in_byte;
    end else begin : g_link
      logic [7:0] prev_tap;
      // Hold the previous lane's tap of the last item; it shifts in next
      always_ff @(posedge clk) begin
        if (accept) begin
          prev_tap <= tap[j-1];
        end
      end
      assign lane_in = prev_tap;
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        mem[ptr] <= lane_in;
      end
      rd_data <= mem[rd_addr];
    end

    assign tap[j]       = rd_data;
    assign tap_match[j] = (rd_data == sync_value);
  end

  // Classify the oldest byte once the line is full
  assign push             = accept && full;
  assign entry.data       = tap[CONFIRM_PACKETS-1];
  assign entry.head_match = tap_match[CONFIRM_PACKETS-1];
  assign entry.all_match  = &tap_match;

endmodule

// ===== design/tsps_queue.sv =====
`timescale 1ns / 1ps

module tsps_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tsps_pkg::tsps_entry_t din,
  input  logic                  pop,
  output logic                  q_valid,
  output logic                  full,
  output tsps_pkg::tsps_entry_t head
);

  localparam int PtrW = $clog2(tsps_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(tsps_pkg::QUEUE_DEPTH + 1);

  tsps_pkg::tsps_entry_t slots [tsps_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_valid = (count != '0);
  assign full    = (count == CntW'(tsps_pkg::QUEUE_DEPTH));
  assign head    = slots[rd_ptr];

  // Store incoming items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

// ===== design/tsps_back.sv =====
`timescale 1ns / 1ps

module tsps_back #(
  parameter int PACKET_BYTES = tsps_pkg::PACKET_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  tsps_pkg::tsps_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  packet_first
);

  localparam int OffW = $clog2(PACKET_BYTES);

  tsps_pkg::tsps_state_t state;
  tsps_pkg::tsps_state_t state_next;
  logic [OffW-1:0] offset;
  logic [OffW-1:0] offset_next;
  logic [OffW-1:0] offset_inc;
  logic            emit;
  logic            first;

  // Take the next item whenever the output register is free or draining
  assign pop = q_valid && (!out_valid || !out_stall);

  assign offset_inc = (offset == OffW'(PACKET_BYTES - 1)) ? '0 : offset + 1'b1;

  // Next lock state
  always_comb begin
    priority if (state == tsps_pkg::TSPS_LOCK && offset != '0) begin
      state_next = tsps_pkg::TSPS_LOCK;
    end else if (state == tsps_pkg::TSPS_LOCK && head.head_match) begin
      state_next = tsps_pkg::TSPS_LOCK;
    end else if (head.all_match) begin
      state_next = tsps_pkg::TSPS_LOCK;
    end else begin
      state_next = tsps_pkg::TSPS_HUNT;
    end
  end

  // Emit decision and packet position
  always_comb begin
    priority if (state == tsps_pkg::TSPS_LOCK && offset != '0) begin
      emit        = 1'b1;
      first       = 1'b0;
      offset_next = offset_inc;
    end else if (state == tsps_pkg::TSPS_LOCK && head.head_match) begin
      emit        = 1'b1;
      first       = 1'b1;
      offset_next = OffW'(1);
    end else if (head.all_match) begin
      emit        = 1'b1;
      first       = 1'b1;
      offset_next = OffW'(1);
    end else begin
      emit        = 1'b0;
      first       = 1'b0;
      offset_next = '0;
    end
  end

  // Update lock tracking on each item taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsps_pkg::TSPS_HUNT;
      offset    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        state  <= state_next;
        offset <= offset_next;
      end
      out_valid <= (out_valid && out_stall) || (pop && emit);
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte     <= head.data;
      packet_first <= first;
    end
  end

  a_mid_packet: assert property (@(posedge clk) disable iff (rst)
    pop && state == tsps_pkg::TSPS_LOCK && offset != '0 |=> out_valid && !packet_first)
    else $error("mid-packet byte not passed unmarked");

  a_drop_unlocks: assert property (@(posedge clk) disable iff (rst)
    pop && !emit |=> state == tsps_pkg::TSPS_HUNT && offset == '0)
    else $error("dropped byte left lock state behind");

  a_first_zero_offset: assert property (@(posedge clk) disable iff (rst)
    pop && emit && first |=> offset == OffW'(1) && state == tsps_pkg::TSPS_LOCK)
    else $error("packet start did not restart the offset");

endmodule

// ===== design/ts_packet_sync_filter_core.sv =====
`timescale 1ns / 1ps

// Transport stream sync filter.
// Input channel (in_valid, in_stall, in_byte): one raw stream byte per item.
// Output channel (out_valid, out_stall, out_byte, packet_first): bytes of
// packets found in sync, with packet_first set on each packet's first byte.
// Config channel (cfg_valid, cfg_ready, cfg_data): writes the sync byte value;
// write only while no items are in flight.
// Bytes run through a delay line of CONFIRM_PACKETS packets; nothing comes
// out until it is full. While hunting, a byte starts lock only if it and the
// bytes one, two, ... packets later all equal the sync value. While locked,
// every byte is passed and each packet start is checked again.
// Throughput: one byte per cycle while neither side stalls. A judged byte
// is written into the queue at the edge that accepts the byte pushing it out
// of the delay line; from the queue it is loaded into the output register.
// The first PACKET_BYTES*CONFIRM_PACKETS-1 bytes are only stored.
// Reset (rst, synchronous): empties the delay line, drops lock, restores sync
// value 0x47; in_stall is high and cfg_ready low while rst is asserted.
// When out_stall is held, the output register holds its item, the four-entry
// queue fills, and then in_stall rises.
module ts_packet_sync_filter_core #(
  parameter int PACKET_BYTES    = tsps_pkg::PACKET_BYTES_DEFAULT,
  parameter int CONFIRM_PACKETS = tsps_pkg::CONFIRM_PACKETS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       packet_first,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]            sync_value;
  logic                  accept;
  logic                  push;
  logic                  pop;
  logic                  q_valid;
  logic                  q_full;
  tsps_pkg::tsps_entry_t entry;
  tsps_pkg::tsps_entry_t head;

  assign cfg_ready = ~rst;
  assign in_stall  = rst | q_full;
  assign accept    = in_valid & ~in_stall;

  // Hold the sync value register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= tsps_pkg::SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_value <= cfg_data;
    end
  end

  tsps_front #(
    .PACKET_BYTES   (PACKET_BYTES),
    .CONFIRM_PACKETS(CONFIRM_PACKETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .sync_value(sync_value),
    .push      (push),
    .entry     (entry)
  );

  tsps_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (entry),
    .pop    (pop),
    .q_valid(q_valid),
    .full   (q_full),
    .head   (head)
  );

  tsps_back #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .packet_first(packet_first)
  );

endmodule

// ===== test/tb_ts_packet_sync_filter_core.sv =====
`timescale 1ns / 1ps

module tb_ts_packet_sync_filter_core;

  localparam int PKT        = tsps_pkg::PACKET_BYTES_DEFAULT;
  localparam int NPKT       = tsps_pkg::CONFIRM_PACKETS_DEFAULT;
  localparam int LINE_DEPTH = PKT * NPKT;
  localparam int NUM_SEGS   = 3;
  localparam int SEG_BYTES  = 150;
  localparam int SETTLE     = 8;
  localparam int DRAIN      = 20;
  localparam int LIMIT      = 4000;

  typedef struct {
    bit [7:0] data;
    bit       first;
  } ts_out_t;

  // Track lock state and the expected stream of in-sync bytes
  class sync_filter_scoreboard;
    bit [7:0]    line_bytes [LINE_DEPTH];
    int unsigned wr_ptr;
    int unsigned fill;
    int unsigned pkt_pos;
    tsps_pkg::tsps_state_t lock_state;
    bit [7:0]    sync_expect;
    ts_out_t     expected_q [$];
    int          mismatches;

    function new();
      wr_ptr      = 0;
      fill        = 0;
      pkt_pos     = 0;
      lock_state  = tsps_pkg::TSPS_HUNT;
      sync_expect = tsps_pkg::SYNC_RESET;
      mismatches  = 0;
    endfunction

    function void set_sync(bit [7:0] v);
      sync_expect = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_out(bit [7:0] data, bit first);
      ts_out_t e;
      e.data  = data;
      e.first = first;
      expected_q.push_back(e);
    endfunction

    // Shift one byte into the line and judge the byte it pushes out
    function void note_byte(bit [7:0] b);
      bit [7:0] oldest;
      bit       hit;
      line_bytes[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1 >= LINE_DEPTH) ? 0 : wr_ptr + 1;
      if (fill < LINE_DEPTH) fill++;
      if (fill < LINE_DEPTH) return;
      oldest = line_bytes[wr_ptr];
      if (lock_state == tsps_pkg::TSPS_LOCK) begin
        if (pkt_pos != 0) begin
          push_out(oldest, 1'b0);
          pkt_pos = (pkt_pos + 1 >= PKT) ? 0 : pkt_pos + 1;
          return;
        end
        if (oldest == sync_expect) begin
          push_out(oldest, 1'b1);
          pkt_pos = 1;
          return;
        end
        // lost sync: judge this same byte as a hunting candidate
        lock_state = tsps_pkg::TSPS_HUNT;
        pkt_pos    = 0;
      end
      hit = 1'b1;
      for (int k = 0; k < NPKT; k++) begin
        if (line_bytes[(wr_ptr + k * PKT) % LINE_DEPTH] != sync_expect) hit = 1'b0;
      end
      if (hit) begin
        lock_state = tsps_pkg::TSPS_LOCK;
        push_out(oldest, 1'b1);
        pkt_pos = 1;
      end
    endfunction

    // Compare one output item with the oldest expectation
    function void check_byte(bit [7:0] data, bit first);
      ts_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item out_byte=%02h packet_first=%0b", $time, data, first);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, e.data, data);
        mismatches++;
      end
      if (first !== e.first) begin
        $display("%0t: packet_first expected %0b actual %0b", $time, e.first, first);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       packet_first;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  sync_filter_scoreboard board;
  bit [7:0] stream_bytes [$];
  int       seg_end [NUM_SEGS];
  bit [7:0] seg_sync [NUM_SEGS];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       idle_cycles = 0;

  ts_packet_sync_filter_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .packet_first (packet_first),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the output side at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Record accepted bytes and check delivered items
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_byte(in_byte);
      if (out_valid && !out_stall) board.check_byte(out_byte, packet_first);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Payload byte, sometimes equal to the sync value to tempt false locks
  function automatic bit [7:0] payload_byte(bit [7:0] sync);
    return ($urandom_range(15) == 0) ? sync : 8'($urandom);
  endfunction

  // Append one packet: a head byte and len-1 payload bytes
  function automatic void add_packet(bit [7:0] sync, bit [7:0] head, int len);
    stream_bytes.push_back(head);
    for (int i = 1; i < len; i++) stream_bytes.push_back(payload_byte(sync));
  endfunction

  // Mostly clean packets, with broken sync bytes, noise and cut packets
  function automatic void add_random_stream(bit [7:0] sync, int target);
    int start;
    int pick;
    int len;
    start = stream_bytes.size();
    while (stream_bytes.size() - start < target) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        add_packet(sync, sync, PKT);
      end else if (pick < 82) begin
        add_packet(sync, sync ^ 8'($urandom_range(1, 255)), PKT);
      end else if (pick < 91) begin
        len = $urandom_range(1, 300);
        for (int i = 0; i < len; i++) begin
          stream_bytes.push_back(($urandom_range(3) == 0) ? sync : 8'($urandom));
        end
      end else begin
        add_packet(sync, sync, $urandom_range(1, PKT - 1));
      end
    end
  endfunction

  task automatic send_byte(input bit [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_sync(input bit [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_sync(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every expected item is out and the pipeline has settled
  task automatic wait_drained(input int cycles);
    while (board.pending() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    bit [7:0] lead [12];
    int       total;
    int       idx;
    board = new();
    lead = '{8'h00, 8'hFF, 8'h47, 8'h01, 8'h80, 8'h7F,
             8'hFE, 8'h55, 8'hAA, 8'h47, 8'h46, 8'h48};
    seg_sync[0] = tsps_pkg::SYNC_RESET;
    seg_sync[1] = 8'h00;
    seg_sync[2] = 8'hFF;

    // Extreme bytes, then clean packets, one lost sync, then random stream
    foreach (lead[i]) stream_bytes.push_back(lead[i]);
    for (int p = 0; p < 4; p++) add_packet(seg_sync[0], seg_sync[0], PKT);
    add_packet(seg_sync[0], ~seg_sync[0], PKT);
    add_packet(seg_sync[0], seg_sync[0], PKT);
    add_random_stream(seg_sync[0], SEG_BYTES / 2);
    seg_end[0] = stream_bytes.size();
    for (int s = 1; s < NUM_SEGS; s++) begin
      add_random_stream(seg_sync[s], SEG_BYTES);
      seg_end[s] = stream_bytes.size();
    end
    total = stream_bytes.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idx = 0;
    for (int s = 0; s < NUM_SEGS; s++) begin
      write_sync(seg_sync[s]);
      @(negedge clk);
      while (idx < seg_end[s]) begin
        // first the sender idles lightly and the receiver stalls heavily, then the reverse, then neither
        if (idx < total / 3) begin
          send_idle_pct  = 9;
          recv_stall_pct = 58;
        end else if (idx < 2 * total / 3) begin
          send_idle_pct  = 58;
          recv_stall_pct = 9;
        end else begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        send_byte(stream_bytes[idx]);
        idx++;
      end
      in_valid <= 1'b0;
      wait_drained((s == NUM_SEGS - 1) ? DRAIN : SETTLE);
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
